>>> hdl/kcf_pkg.sv
// kcf_pkg: shared types, constants and arithmetic helpers for the kaleidoscope fold
// holds the fixed point format, the queue entry layout and the rounding multiply
// no dependencies
package kcf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int VW        = FRAC_BITS + 4;
    localparam int OUT_W     = 19;
    localparam int IN_W      = 32;

    typedef logic signed [VW-1:0] val_t;

    localparam logic [2:0] MODE_BOX  = 3'd0;
    localparam logic [2:0] MODE_OCT  = 3'd1;
    localparam logic [2:0] MODE_TRI  = 3'd2;
    localparam logic [2:0] MODE_RHO  = 3'd3;
    localparam logic [2:0] MODE_MESH = 3'd4;
    localparam logic [2:0] MODE_HEX  = 3'd5;
    localparam logic [2:0] MODE_DODEC  = 3'd6;
    localparam logic [2:0] MODE_UNUSED = 3'd7;
    localparam logic [2:0] MODE_RESET = MODE_OCT;

    // Q2.30 constants
    localparam logic [31:0] K_SQ3    = 32'd1859775393;
    localparam logic [31:0] K_2SQ3   = 32'd3719550787;
    localparam logic [31:0] K_SQ3H   = 32'd929887697;
    localparam logic [31:0] K_INVSQ3 = 32'd619925131;
    localparam logic [31:0] K_OFFS   = 32'd226908346;
    localparam logic [31:0] K_HALF   = 32'd536870912;

    localparam longint ONE_L = longint'(1) <<< FRAC_BITS;
    localparam longint RND_L = longint'(1) <<< 29;

    localparam val_t ONE_V  = val_t'(ONE_L);
    localparam val_t HALF_V = val_t'(ONE_L >>> 1);
    localparam val_t QTR_V  = val_t'(ONE_L >>> 2);
    localparam val_t C15_V  = val_t'(ONE_L + (ONE_L >>> 1));

    localparam val_t KC_SQ3  = val_t'((ONE_L * longint'(K_SQ3) + RND_L) >>> 30);
    localparam val_t KC_2SQ3 = val_t'((ONE_L * longint'(K_2SQ3) + RND_L) >>> 30);
    localparam val_t KC_INV  = val_t'((ONE_L * longint'(K_INVSQ3) + RND_L) >>> 30);
    localparam val_t KC_OFFS = val_t'((ONE_L * longint'(K_OFFS) + RND_L) >>> 30);

    localparam int OUT_MAX = 262143;
    localparam int OUT_MIN = -262144;

    typedef enum logic [1:0] {KM_NONE, KM_2SQ3, KM_SQ3} kmul_t;

    // rotation forms, a = x after subtract, b = y
    // a: x=-h(a)+s(b) y=-h(b)-s(a)   b: x=-h(a)-s(b) y=-h(b)+s(a)
    // c: x=-h(a)+s(b) y= h(b)+s(a)   d: x=-h(a)-s(b) y= h(b)-s(a)
    typedef enum logic [2:0] {ROT_NONE, ROT_A, ROT_B, ROT_C, ROT_D} rot_t;

    typedef struct packed {
        val_t  xv;
        val_t  yv;
        val_t  xsub;
        val_t  addx;
        logic  addy;
        kmul_t kmul;
        rot_t  rot;
        logic  fin;
    } kcf_op_t;

    // v * k / 2^30, rounded to nearest, ties away from zero
    function automatic val_t mulk(val_t v, logic [31:0] k);
        logic [VW-1:0]    m;
        logic [VW+31:0]   p;
        logic [VW+31:0]   q;
        val_t             r;
        m = v[VW-1] ? VW'(-v) : VW'(v);
        p = (VW+32)'(m) * (VW+32)'(k) + (VW+32)'(RND_L);
        q = p >> 30;
        r = val_t'(q[VW-1:0]);
        return v[VW-1] ? -r : r;
    endfunction

    function automatic val_t sym_f(val_t v);
        val_t r;
        r = (v > HALF_V) ? ONE_V - v : v;
        return r <<< 1;
    endfunction

    function automatic logic [OUT_W-1:0] sat_f(val_t v);
        logic signed [31:0] w;
        w = 32'(v);
        if (w > OUT_MAX) w = OUT_MAX;
        if (w < OUT_MIN) w = OUT_MIN;
        return w[OUT_W-1:0];
    endfunction

endpackage

>>> hdl/kcf_front.sv
// kcf_front: wraps a coordinate pair to its fraction and folds it by mode
// finishes the multiply-free modes and prepares the rotation op for the rest
// depends on kcf_pkg
module kcf_front import kcf_pkg::*; (
    input  logic [2:0]            fold_mode,
    input  logic [IN_W-1:0]       x_in,
    input  logic [IN_W-1:0]       y_in,
    output kcf_op_t               op
);

    always_comb begin
        val_t x0, y0, x, y, t, x6, fr, x2;
        logic [2:0] n;
        x0 = val_t'({1'b0, x_in[FRAC_BITS-1:0]});
        y0 = val_t'({1'b0, y_in[FRAC_BITS-1:0]});
        x = x0;
        y = y0;
        t = '0;
        x6 = '0;
        fr = '0;
        x2 = '0;
        n = '0;
        op.xsub = '0;
        op.addx = '0;
        op.addy = 1'b0;
        op.kmul = KM_NONE;
        op.rot  = ROT_NONE;
        op.fin  = 1'b0;
        case (fold_mode)
            MODE_BOX: begin
                x = sym_f(x0);
                y = sym_f(y0);
            end
            MODE_OCT: begin
                x = sym_f(x0);
                y = sym_f(y0);
                if (y > x) begin
                    t = x; x = y; y = t;
                end
            end
            MODE_TRI: begin
                x = sym_f(x0);
                y = sym_f(y0);
                if (y < ONE_V - x) begin
                    t = ONE_V - x; x = ONE_V - y; y = t;
                end
            end
            MODE_RHO: begin
                if (y > x) begin
                    t = x; x = y; y = t;
                end
                if (y < ONE_V - x) begin
                    t = ONE_V - x; x = ONE_V - y; y = t;
                end
                if (y > C15_V - x) begin
                    t = C15_V - x; x = C15_V - y; y = t;
                end
                if (y < x - HALF_V) begin
                    t = x - HALF_V; x = y + HALF_V; y = t;
                end
                x = (x - HALF_V) <<< 1;
                y = (y - QTR_V) <<< 1;
            end
            MODE_MESH: begin
                x = sym_f(x0);
                y = sym_f(sym_f(y0));
                if (x >= HALF_V) begin
                    x = (ONE_V - x) <<< 1;
                    if (y > x) begin
                        t = x; x = y; y = t;
                    end
                end else begin
                    x = x <<< 1;
                    if (y < ONE_V - x) begin
                        t = ONE_V - x; x = ONE_V - y; y = t;
                    end
                end
            end
            MODE_HEX: begin
                y = sym_f(y0);
                x6 = (x0 <<< 2) + (x0 <<< 1);
                n = x6[FRAC_BITS+2:FRAC_BITS];
                fr = val_t'({1'b0, x6[FRAC_BITS-1:0]});
                if (!n[0]) begin
                    if (y < fr) n = n + 3'd1;
                end else begin
                    if (y > ONE_V - fr) n = n + 3'd1;
                end
                op.kmul = KM_2SQ3;
                op.fin  = 1'b1;
                case (n)
                    3'd1: ;
                    3'd2: begin
                        op.xsub = KC_SQ3; y = ONE_V - y; op.rot = ROT_A;
                    end
                    3'd3: begin
                        op.xsub = KC_SQ3; y = y - ONE_V; op.rot = ROT_B;
                    end
                    3'd4: begin
                        op.xsub = KC_SQ3; y = ONE_V - y;
                    end
                    3'd5: begin
                        op.xsub = KC_2SQ3; op.rot = ROT_A;
                    end
                    3'd6: begin
                        op.xsub = KC_2SQ3; op.rot = ROT_C;
                    end
                    default: op.rot = ROT_C;
                endcase
            end
            default: begin
                // dodecagon, also taken for the unused code
                x = sym_f(x0);
                y = sym_f(sym_f(y0));
                if (y > ONE_V - x) begin
                    x = ONE_V - x; y = ONE_V - y;
                end
                x2 = (x <<< 1) + x;
                op.kmul = KM_SQ3;
                op.addx = KC_OFFS;
                if (y > ONE_V - x2) begin
                    if (y < x2 - ONE_V) begin
                        op.xsub = KC_INV;
                        op.rot  = ROT_B;
                        op.addx = KC_INV + KC_OFFS;
                    end else begin
                        y = y - ONE_V;
                        op.rot  = ROT_D;
                        op.addy = 1'b1;
                    end
                end
            end
        endcase
        op.xv = x;
        op.yv = y;
    end

endmodule

>>> hdl/kcf_fifo.sv
// kcf_fifo: four-entry queue of fold ops between front and back
// depends on kcf_pkg
module kcf_fifo import kcf_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    wr_en,
    input  kcf_op_t wr_data,
    output logic    full,
    input  logic    rd_en,
    output logic    rd_valid,
    output kcf_op_t rd_data
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    kcf_op_t        mem_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [AW:0]    count_reg, count_next;

    assign full     = (count_reg == (AW+1)'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg + (wr_en ? AW'(1) : AW'(0));
        rd_ptr_next = rd_ptr_reg + (rd_en ? AW'(1) : AW'(0));
        count_next  = count_reg + (wr_en ? (AW+1)'(1) : '0) - (rd_en ? (AW+1)'(1) : '0);
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hdl/kcf_back.sv
// kcf_back: four-stage rotation pipeline, the last stage being the output register
// scale by sqrt 3 terms, rotate, offset, final scale and saturate
// depends on kcf_pkg
module kcf_back import kcf_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               op_valid,
    input  kcf_op_t            op,
    output logic               op_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [OUT_W-1:0]   x_out,
    output logic [OUT_W-1:0]   y_out
);

    logic    en;
    logic    v1_reg, v2_reg, v3_reg, v4_reg;
    kcf_op_t op1_reg;
    kcf_op_t op_m;
    val_t    a2_reg, b2_reg, ha2_reg, sa2_reg, hb2_reg, sb2_reg, addx2_reg;
    logic    addy2_reg, fin2_reg, fin3_reg;
    rot_t    rot2_reg;
    val_t    x3_reg, y3_reg;
    logic [OUT_W-1:0] x4_reg, y4_reg;

    val_t    xm_next, a_next, xr, yr, xf_next;

    assign en       = !v4_reg || m_ready;
    assign op_ready = en;
    assign m_valid  = v4_reg;
    assign x_out    = x4_reg;
    assign y_out    = y4_reg;

    always_comb begin
        case (op.kmul)
            KM_2SQ3: xm_next = mulk(op.xv, K_2SQ3);
            KM_SQ3:  xm_next = mulk(op.xv, K_SQ3);
            default: xm_next = op.xv;
        endcase
        op_m    = op;
        op_m.xv = xm_next;
        a_next = op1_reg.xv - op1_reg.xsub;
        case (rot2_reg)
            ROT_A: begin
                xr = sb2_reg - ha2_reg; yr = -hb2_reg - sa2_reg;
            end
            ROT_B: begin
                xr = -ha2_reg - sb2_reg; yr = sa2_reg - hb2_reg;
            end
            ROT_C: begin
                xr = sb2_reg - ha2_reg; yr = hb2_reg + sa2_reg;
            end
            ROT_D: begin
                xr = -ha2_reg - sb2_reg; yr = hb2_reg - sa2_reg;
            end
            default: begin
                xr = a2_reg; yr = b2_reg;
            end
        endcase
        xf_next = fin3_reg ? mulk(x3_reg, K_SQ3H) : x3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= op_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op1_reg    <= op_m;
            a2_reg     <= a_next;
            b2_reg     <= op1_reg.yv;
            ha2_reg    <= mulk(a_next, K_HALF);
            sa2_reg    <= mulk(a_next, K_SQ3H);
            hb2_reg    <= mulk(op1_reg.yv, K_HALF);
            sb2_reg    <= mulk(op1_reg.yv, K_SQ3H);
            addx2_reg  <= op1_reg.addx;
            addy2_reg  <= op1_reg.addy;
            rot2_reg   <= op1_reg.rot;
            fin2_reg   <= op1_reg.fin;
            x3_reg     <= xr + addx2_reg;
            y3_reg     <= yr + (addy2_reg ? ONE_V : val_t'(0));
            fin3_reg   <= fin2_reg;
            x4_reg     <= sat_f(xf_next);
            y4_reg     <= sat_f(y3_reg);
        end
    end

endmodule

>>> hdl/kaleidoscope_coordinate_fold_core.sv
// kaleidoscope coordinate fold, top level
// an input beat is written to the queue, then passes the four back stages to the result beat
// throughput: one beat per cycle while m_tready stays high, set by the four-stage back pipeline
// the four-entry queue absorbs input beats while the output is stalled
// reset (aresetn low, synchronous) empties the queue and pipeline, fold_mode goes to octagon
module kaleidoscope_coordinate_fold_core import kcf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // x_in [31:0], y_in [63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // x_out [18:0], y_out [37:19], zero [39:38]
);

    logic [2:0]       fold_mode_reg;
    kcf_op_t          front_op, q_op;
    logic             q_full, q_valid, back_ready, wr_en, rd_en;
    logic [OUT_W-1:0] x_out, y_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fold_mode_reg <= MODE_RESET;
        end else if (cfg_we) begin
            fold_mode_reg <= cfg_wdata;
        end
    end

    assign s_tready = !q_full;
    assign wr_en    = s_tvalid && !q_full;
    assign rd_en    = q_valid && back_ready;

    kcf_front u_front (
        .fold_mode (fold_mode_reg),
        .x_in      (s_tdata[31:0]),
        .y_in      (s_tdata[63:32]),
        .op        (front_op)
    );

    kcf_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (wr_en),
        .wr_data  (front_op),
        .full     (q_full),
        .rd_en    (rd_en),
        .rd_valid (q_valid),
        .rd_data  (q_op)
    );

    kcf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op_valid (q_valid),
        .op       (q_op),
        .op_ready (back_ready),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .x_out    (x_out),
        .y_out    (y_out)
    );

    assign m_tdata = {2'b00, y_out, x_out};

endmodule

>>> tb/sv/kcf_fold_checker.sv
// kcf_fold_checker: watches both streams of the kaleidoscope fold core, predicts each result
// beat from the accepted input beat and the current fold mode, and counts mismatches
// depends on kcf_pkg for the mode codes and the Q2.30 constants
module kcf_fold_checker import kcf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ONE  = longint'(1) <<< FRAC_BITS;
    localparam longint HALF = ONE >>> 1;
    localparam longint QTR  = ONE >>> 2;

    logic [2:0]   mode_q;
    logic [37:0]  folded_q[$];

    // coordinate times a Q2.30 constant, rounded half away from zero
    function automatic longint scale_q30(longint v, logic [31:0] k);
        longint unsigned mag;
        longint unsigned prod;
        mag  = (v < 0) ? longint'(-v) : longint'(v);
        prod = (mag * longint'(k) + (longint'(1) <<< 29)) >> 30;
        return (v < 0) ? -longint'(prod) : longint'(prod);
    endfunction

    function automatic longint mirror(longint v);
        return ((v > HALF) ? ONE - v : v) * 2;
    endfunction

    function automatic logic [18:0] clamp19(longint v);
        if (v > OUT_MAX) v = OUT_MAX;
        if (v < OUT_MIN) v = OUT_MIN;
        return v[18:0];
    endfunction

    function automatic logic [37:0] fold_coord(logic [31:0] xi, logic [31:0] yi,
                                               logic [2:0] md);
        longint x, y, t, xr, yr, x6, fr, n, x2, kb, s;
        x = longint'(xi[FRAC_BITS-1:0]);
        y = longint'(yi[FRAC_BITS-1:0]);
        s = longint'(K_SQ3H);
        case (md)
            MODE_BOX: begin
                x = mirror(x); y = mirror(y);
            end
            MODE_OCT: begin
                x = mirror(x); y = mirror(y);
                if (y > x) begin t = x; x = y; y = t; end
            end
            MODE_TRI: begin
                x = mirror(x); y = mirror(y);
                if (y < ONE - x) begin t = ONE - x; x = ONE - y; y = t; end
            end
            MODE_RHO: begin
                if (y > x) begin t = x; x = y; y = t; end
                if (y < ONE - x) begin t = ONE - x; x = ONE - y; y = t; end
                if (y > ONE + HALF - x) begin
                    t = ONE + HALF - x; x = ONE + HALF - y; y = t;
                end
                if (y < x - HALF) begin t = x - HALF; x = y + HALF; y = t; end
                x = (x - HALF) * 2;
                y = (y - QTR) * 2;
            end
            MODE_MESH: begin
                x = mirror(x); y = mirror(y); y = mirror(y);
                if (x >= HALF) begin
                    x = (ONE - x) * 2;
                    if (y > x) begin t = x; x = y; y = t; end
                end else begin
                    x = x * 2;
                    if (y < ONE - x) begin t = ONE - x; x = ONE - y; y = t; end
                end
            end
            MODE_HEX: begin
                y = mirror(y);
                x6 = x * 6;
                n = x6 >>> FRAC_BITS;
                fr = x6 & (ONE - 1);
                if (n[0] == 1'b0) begin
                    if (y < fr) n++;
                end else begin
                    if (y > ONE - fr) n++;
                end
                x = scale_q30(x, K_2SQ3);
                case (n)
                    1: ;
                    2: begin
                        x = x - scale_q30(ONE, K_SQ3); y = ONE - y;
                        xr = -scale_q30(x, K_HALF) + scale_q30(y, s);
                        yr = -scale_q30(y, K_HALF) - scale_q30(x, s);
                        x = xr; y = yr;
                    end
                    3: begin
                        x = x - scale_q30(ONE, K_SQ3); y = y - ONE;
                        xr = -scale_q30(x, K_HALF) - scale_q30(y, s);
                        yr = -scale_q30(y, K_HALF) + scale_q30(x, s);
                        x = xr; y = yr;
                    end
                    4: begin
                        x = x - scale_q30(ONE, K_SQ3); y = ONE - y;
                    end
                    5: begin
                        x = x - scale_q30(ONE, K_2SQ3);
                        xr = -scale_q30(x, K_HALF) + scale_q30(y, s);
                        yr = -scale_q30(y, K_HALF) - scale_q30(x, s);
                        x = xr; y = yr;
                    end
                    default: begin
                        if (n == 6) x = x - scale_q30(ONE, K_2SQ3);
                        x = -x;
                        xr = scale_q30(x, K_HALF) + scale_q30(y, s);
                        yr = scale_q30(y, K_HALF) - scale_q30(x, s);
                        x = xr; y = yr;
                    end
                endcase
                x = scale_q30(x, s);
            end
            default: begin
                // dodecagon, mode seven lands here too
                kb = scale_q30(ONE, K_INVSQ3);
                x = mirror(x); y = mirror(y); y = mirror(y);
                if (y > ONE - x) begin x = ONE - x; y = ONE - y; end
                x2 = x * 3;
                x = scale_q30(x, K_SQ3);
                if (y > ONE - x2) begin
                    if (y < x2 - ONE) begin
                        x = x - kb;
                        xr = -scale_q30(x, K_HALF) - scale_q30(y, s);
                        yr = -scale_q30(y, K_HALF) + scale_q30(x, s);
                        x = xr + kb; y = yr;
                    end else begin
                        y = y - ONE;
                        xr = scale_q30(x, K_HALF) + scale_q30(y, s);
                        yr = scale_q30(y, K_HALF) - scale_q30(x, s);
                        x = -xr; y = yr + ONE;
                    end
                end
                x = x + scale_q30(ONE, K_OFFS);
            end
        endcase
        return {clamp19(y), clamp19(x)};
    endfunction

    always @(posedge aclk) begin
        logic [37:0] want;
        int          errs;
        errs = 0;
        if (!aresetn) begin
            mode_q <= MODE_RESET;
            folded_q.delete();
            fail_count <= 0;
            pending <= 0;
        end else begin
            if (cfg_we) mode_q <= cfg_wdata;
            if (s_tvalid && s_tready)
                folded_q.push_back(fold_coord(s_tdata[31:0], s_tdata[63:32], mode_q));
            if (m_tvalid && m_tready) begin
                if (folded_q.size() == 0) begin
                    $error("unexpected result beat %h", m_tdata);
                    errs++;
                end else begin
                    want = folded_q.pop_front();
                    if (m_tdata[18:0] !== want[18:0]) begin
                        $error("x_out expected %h actual %h", want[18:0], m_tdata[18:0]);
                        errs++;
                    end
                    if (m_tdata[37:19] !== want[37:19]) begin
                        $error("y_out expected %h actual %h", want[37:19], m_tdata[37:19]);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            pending <= folded_q.size();
        end
    end

endmodule

>>> tb/sv/kaleidoscope_coordinate_fold_core_tb.sv
// kaleidoscope_coordinate_fold_core_tb: drives coordinate beats through every fold mode
// under varied sender and receiver idling and prints the verdict
// depends on kcf_pkg, the core and kcf_fold_checker
module kaleidoscope_coordinate_fold_core_tb import kcf_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [2:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    int          fail_count;
    int          pending;
    int          send_idle_pct;
    int          recv_idle_pct;
    logic        want_hold;

    kaleidoscope_coordinate_fold_core i_dut (
        .aclk, .aresetn, .cfg_we, .cfg_wdata,
        .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata
    );

    kcf_fold_checker i_checker (
        .aclk, .aresetn, .cfg_we, .cfg_wdata,
        .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata,
        .fail_count, .pending
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

    // receiver side, with one long hold-off when asked
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (want_hold && !hold_done) begin
                hold_done = 1;
                hold_left = 120;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_beat(logic [31:0] xv, logic [31:0] yv);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {yv, xv};
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        @(negedge aclk);
    endtask

    // fraction near the fold boundaries, whole part random
    function automatic logic [31:0] edgy_coord();
        logic [15:0] fr[10] = '{16'h0000, 16'hffff, 16'h8000, 16'h8001, 16'h7fff,
                                16'h4000, 16'h5555, 16'haaab, 16'h2aab, 16'hd555};
        logic [31:0] v;
        v = $urandom;
        v[15:0] = fr[$urandom_range(9)] + 16'($urandom_range(2)) - 16'd1;
        return v;
    endfunction

    task automatic write_mode(logic [2:0] md);
        wait (pending == 0);
        repeat (8) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= md;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(int idle_kind, int count);
        logic [31:0] corners[8] = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000,
                                    32'h7fff_ffff, 32'h0000_8000, 32'hffff_0000,
                                    32'h0001_0000, 32'h0000_7fff};
        case (idle_kind)
            0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            1: begin send_idle_pct = 50; recv_idle_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_idle_pct = 50; end
            default: begin send_idle_pct = 16; recv_idle_pct = 16; end
        endcase
        for (int i = 0; i < 8; i++) send_beat(corners[i], corners[7 - i]);
        send_beat(32'h0000_5555, 32'h0000_ffff);
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(2))
                0: send_beat($urandom, $urandom);
                1: send_beat(edgy_coord(), edgy_coord());
                default: send_beat(edgy_coord(), $urandom);
            endcase
        end
        s_tvalid <= 1'b0;
    endtask

    initial begin
        logic [2:0] order[8] = '{MODE_BOX, MODE_TRI, MODE_RHO, MODE_MESH, MODE_HEX,
                                 MODE_DODEC, MODE_UNUSED, MODE_OCT};
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        want_hold = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        // reset mode first, with the long receiver hold-off
        want_hold <= 1'b1;
        run_phase(0, 80);
        for (int p = 0; p < 8; p++) begin
            write_mode(order[p]);
            run_phase((p + 1) % 4, 85);
        end
        wait (pending == 0);
        repeat (20) @(negedge aclk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

>>> filelist.f
hdl/kcf_pkg.sv
hdl/kcf_front.sv
hdl/kcf_fifo.sv
hdl/kcf_back.sv
hdl/kaleidoscope_coordinate_fold_core.sv
tb/sv/kcf_fold_checker.sv
tb/sv/kaleidoscope_coordinate_fold_core_tb.sv
